### hdl/adaptive_per_stream_sample_throttle_macros.svh
// Assertion macros shared by the throttle RTL.
`ifndef ADAPTIVE_PER_STREAM_SAMPLE_THROTTLE_MACROS_SVH
`define ADAPTIVE_PER_STREAM_SAMPLE_THROTTLE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define APST_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define APST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/apst_pkg.sv
// Types, constants and helpers for the adaptive per-stream sample throttle.
package apst_pkg;

	localparam int TIME_W = 48;
	localparam int WIN_W  = 16;
	localparam int CNT_W  = 32;
	localparam int SID_W  = 4;
	localparam int REG_W  = 3;

	typedef logic [TIME_W-1:0] time_t;
	typedef logic [WIN_W-1:0]  win_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [REG_W-1:0]  reg_idx_t;

	localparam reg_idx_t REG_BASE_SAMPLE   = 3'd0;
	localparam reg_idx_t REG_MAX_WIN       = 3'd1;
	localparam reg_idx_t REG_STEP          = 3'd2;
	localparam reg_idx_t REG_ADAPT_ENABLE  = 3'd3;
	localparam reg_idx_t REG_WARN_ENABLE   = 3'd4;
	localparam reg_idx_t REG_WARN_INTERVAL = 3'd5;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	localparam win_t RST_BASE_SAMPLE   = 16'd1000;
	localparam win_t RST_MAX_WIN       = 16'd5000;
	localparam win_t RST_STEP          = 16'd100;
	localparam win_t RST_WARN_INTERVAL = 16'd1000;

	localparam win_t  MIN_STEP_MS = 16'd100;
	localparam win_t  MIN_WARN_MS = 16'd200;
	localparam time_t QUIET_MS    = 48'd5000;

	typedef struct packed {
		win_t base_sample;
		win_t max_win;
		win_t step;
		logic adapt_enable;
		logic warn_enable;
		win_t warn_interval;
	} cfg_t;

	// true when now is at least span after then; never when now is before then
	function automatic logic elapsed_ms(input time_t now, input time_t then_t,
	                                    input time_t span);
		time_t diff;
		diff = now - then_t;
		return (now >= then_t) && (diff >= span);
	endfunction

endpackage

### hdl/apst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module apst_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hdl/adaptive_per_stream_sample_throttle.sv
// Top level of the adaptive per-stream sample throttle.
//
//  channel | dir | handshake            | beat
//  in      | in  | in_valid / in_ready   | op, src_id, record_time_ms, now_ms, drop_count
//  out     | out | out_valid / out_ready | keep, window_ms, warn, drop_delta
//  cfg     | in  | cfg_we               | cfg_index, cfg_data
//
// One beat per cycle sustained while out_ready keeps up; a result passes stage 1 and the output register.
// The limit is the last-kept table: one RAM read on accept, judged in stage 1 from the registered read data.
// Reset clears the table valid bits and loads the register reset values at once.
// A stalled result holds in the output register while one more beat waits in stage 1.
`include "adaptive_per_stream_sample_throttle_macros.svh"

module adaptive_per_stream_sample_throttle
	import apst_pkg::*;
#(
	parameter int NUM_STREAMS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          op,
	input  logic [3:0]    src_id,
	input  logic [47:0]   record_time_ms,
	input  logic [47:0]   now_ms,
	input  logic [31:0]   drop_count,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          keep,
	output logic [15:0]   window_ms,
	output logic          warn,
	output logic [31:0]   drop_delta,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [15:0]   cfg_data
);

	localparam int IDX_W   = NUM_STREAMS > 1 ? $clog2(NUM_STREAMS) : 1;
	localparam int SID_CNT = 2 ** SID_W;

	typedef logic [IDX_W-1:0] idx_t;

	cfg_t cfg_q;

	win_t  cur_win_q;
	cnt_t  seen_drop_q;
	time_t last_warn_q;
	time_t last_act_q;
	logic [NUM_STREAMS-1:0] tbl_vld_q;

	logic  s1_vld_q;
	logic  op_s1;
	idx_t  sid_s1;
	time_t rtime_s1;
	time_t now_s1;
	cnt_t  drops_s1;
	logic  fwd_s1;
	time_t fwd_data_s1;

	logic out_vld_q;
	logic keep_q;
	win_t win_q;
	logic warn_q;
	cnt_t delta_q;

	logic  accept;
	logic  advance;
	idx_t  sid_map [SID_CNT];
	idx_t  sid_in;
	time_t ram_rdata;
	time_t last_kept;
	logic  too_soon;
	logic  is_record;
	logic  keep_c;
	logic  tbl_we;
	logic  new_drops;
	cnt_t  delta_c;
	win_t  interval;
	win_t  estep;
	win_t  limit;
	logic [WIN_W:0] grown;
	win_t  grown_win;
	win_t  shrunk_win;
	logic  warn_c;
	logic  shrink;
	win_t  win_nx;

	for (genvar g = 0; g < SID_CNT; g++) begin : g_sid_map
		assign sid_map[g] = IDX_W'(g % NUM_STREAMS);
	end

	assign sid_in   = sid_map[src_id];
	assign advance  = s1_vld_q && (!out_vld_q || out_ready);
	assign in_ready = !s1_vld_q || advance;
	assign accept   = in_valid && in_ready;

	apst_ram #(
		.WIDTH (TIME_W),
		.DEPTH (NUM_STREAMS)
	) u_last_kept (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (sid_s1),
		.wdata (rtime_s1),
		.re    (accept),
		.raddr (sid_in),
		.rdata (ram_rdata)
	);

	// judge the record
	always_comb begin
		last_kept = '0;
		if (tbl_vld_q[sid_s1]) begin
			last_kept = fwd_s1 ? fwd_data_s1 : ram_rdata;
		end
		is_record = (op_s1 == OP_RECORD);
		too_soon  = (last_kept != '0) &&
		            !elapsed_ms(rtime_s1, last_kept, TIME_W'(cur_win_q));
		keep_c    = is_record && ((cur_win_q == '0) || !too_soon);
		tbl_we    = advance && is_record && (cur_win_q != '0) && !too_soon;
	end

	// drops, warning and window adaptation
	always_comb begin
		new_drops  = drops_s1 > seen_drop_q;
		delta_c    = new_drops ? drops_s1 - seen_drop_q : '0;
		interval   = cfg_q.warn_interval < MIN_WARN_MS ? MIN_WARN_MS : cfg_q.warn_interval;
		estep      = cfg_q.step < MIN_STEP_MS ? MIN_STEP_MS : cfg_q.step;
		limit      = cfg_q.max_win > cfg_q.base_sample ? cfg_q.max_win
		                                               : cfg_q.base_sample;
		grown      = {1'b0, cur_win_q} + {1'b0, estep};
		grown_win  = grown < {1'b0, limit} ? grown[WIN_W-1:0] : limit;
		shrunk_win = (cur_win_q - cfg_q.base_sample) <= estep ? cfg_q.base_sample
		                                                     : cur_win_q - estep;
		warn_c     = new_drops && cfg_q.warn_enable &&
		             ((last_warn_q == '0) ||
		              elapsed_ms(now_s1, last_warn_q, TIME_W'(interval)));
		shrink     = !new_drops && cfg_q.adapt_enable &&
		             (cur_win_q > cfg_q.base_sample) && (last_act_q != '0) &&
		             elapsed_ms(now_s1, last_act_q, QUIET_MS);
		win_nx     = cur_win_q;
		if (new_drops && cfg_q.adapt_enable) begin
			win_nx = grown_win;
		end else if (shrink) begin
			win_nx = shrunk_win;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_sample   <= RST_BASE_SAMPLE;
			cfg_q.max_win       <= RST_MAX_WIN;
			cfg_q.step          <= RST_STEP;
			cfg_q.adapt_enable  <= 1'b1;
			cfg_q.warn_enable   <= 1'b1;
			cfg_q.warn_interval <= RST_WARN_INTERVAL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE_SAMPLE:   cfg_q.base_sample   <= cfg_data;
				REG_MAX_WIN:       cfg_q.max_win       <= cfg_data;
				REG_STEP:          cfg_q.step          <= cfg_data;
				REG_ADAPT_ENABLE:  cfg_q.adapt_enable  <= cfg_data[0];
				REG_WARN_ENABLE:   cfg_q.warn_enable   <= cfg_data[0];
				REG_WARN_INTERVAL: cfg_q.warn_interval <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_win_q   <= RST_BASE_SAMPLE;
			seen_drop_q <= '0;
			last_warn_q <= '0;
			last_act_q  <= '0;
			tbl_vld_q   <= '0;
		end else begin
			if (cfg_we && (cfg_index == REG_BASE_SAMPLE)) begin
				cur_win_q <= cfg_data;
			end else if (advance) begin
				cur_win_q <= win_nx;
			end
			if (advance) begin
				if (new_drops) begin
					seen_drop_q <= drops_s1;
					last_act_q  <= now_s1;
				end else if (shrink) begin
					last_act_q  <= now_s1;
				end
				if (warn_c) begin
					last_warn_q <= now_s1;
				end
			end
			if (tbl_we) begin
				tbl_vld_q[sid_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_vld_q <= 1'b1;
			end else if (advance) begin
				s1_vld_q <= 1'b0;
			end
			if (advance) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// stage 1 payload; catch a table write to the same stream at the accept edge
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= op;
			sid_s1      <= sid_in;
			rtime_s1    <= record_time_ms;
			now_s1      <= now_ms;
			drops_s1    <= drop_count;
			fwd_s1      <= tbl_we && (sid_s1 == sid_in);
			fwd_data_s1 <= rtime_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			keep_q  <= keep_c;
			win_q   <= win_nx;
			warn_q  <= warn_c;
			delta_q <= delta_c;
		end
	end

	assign out_valid  = out_vld_q;
	assign keep       = keep_q;
	assign window_ms  = win_q;
	assign warn       = warn_q;
	assign drop_delta = delta_q;

	`APST_ASSERT_NEXT(a_tick_no_keep, advance && (op_s1 == OP_TICK), !keep_q, "tick beat was kept")
	`APST_ASSERT_NOW(a_warn_has_delta, out_vld_q && warn_q, delta_q != '0, "warn without new drops")
	`APST_ASSERT_NEXT(a_seen_tracks, advance && new_drops, seen_drop_q == $past(drops_s1), "seen count not updated")
	`APST_ASSERT_NEXT(a_no_grow_quiet, advance && !new_drops && !cfg_we, cur_win_q <= $past(cur_win_q), "window grew without drops")

endmodule
